// File: rtl/tsm_pkg.sv
// Shared types, codes and constants for the two-axis coordinated step mover.
package tsm_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int IN_W         = 24;
  localparam int LEN_W        = 23;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = {LEN_W{1'b1}};

  localparam logic REG_X_LEN = 1'b0;
  localparam logic REG_Y_LEN = 1'b1;

  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_ABS  = 2'd1,
    K_REL  = 2'd2,
    K_HOME = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  typedef struct packed {
    logic              step_x;
    logic              dir_x;
    logic              step_y;
    logic              dir_y;
    logic              busy_res;
    status_t           status;
    logic [IN_W-1:0]   x_now;
    logic [IN_W-1:0]   y_now;
  } res_t;

endpackage

// File: rtl/tsm_if.sv
// Request and result channel interfaces of the step mover.
interface tsm_in_if
  import tsm_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic signed [IN_W-1:0] x_value;
  logic signed [IN_W-1:0] y_value;

  modport source (output valid, kind, x_value, y_value, input ready);
  modport sink   (input valid, kind, x_value, y_value, output ready);
endinterface

interface tsm_out_if
  import tsm_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   step_x;
  logic                   dir_x;
  logic                   step_y;
  logic                   dir_y;
  logic                   busy_res;
  status_t                status;
  logic signed [IN_W-1:0] x_now;
  logic signed [IN_W-1:0] y_now;

  modport source (output valid, step_x, dir_x, step_y, dir_y, busy_res, status,
                  x_now, y_now, input ready);
  modport sink   (input valid, step_x, dir_x, step_y, dir_y, busy_res, status,
                  x_now, y_now, output ready);
endinterface

// File: rtl/tsm_cfg_regs.sv
// APB register block holding the axis length limits.
module tsm_cfg_regs
  import tsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  x_len,
  output logic [LEN_W-1:0]  y_len
);

  logic [LEN_W-1:0] x_len_r;
  logic [LEN_W-1:0] y_len_r;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_len_r <= LEN_RESET;
      y_len_r <= LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_LEN: x_len_r <= pwdata[LEN_W-1:0];
        REG_Y_LEN: y_len_r <= pwdata[LEN_W-1:0];
        default:   x_len_r <= x_len_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_LEN: prdata = APB_DW'(x_len_r);
      REG_Y_LEN: prdata = APB_DW'(y_len_r);
      default:   prdata = '0;
    endcase
  end

  assign x_len = x_len_r;
  assign y_len = y_len_r;

endmodule

// File: rtl/tsm_core.sv
// Request register, position and DDA state, and the per-request update logic.
module tsm_core
  import tsm_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  tsm_in_if.sink           in_ch,
  input  logic [LEN_W-1:0] x_len,
  input  logic [LEN_W-1:0] y_len,
  input  logic             res_ready,
  output logic             res_valid,
  output res_t             res
);

  localparam int P  = POS_BITS;
  localparam int EW = ((P > IN_W) ? P : IN_W) + 2;
  localparam int DW = P + 2;
  localparam longint PMAX_L = (longint'(1) <<< (P - 1)) - 1;
  localparam longint PMIN_L = -(longint'(1) <<< (P - 1));
  localparam logic signed [EW-1:0] PosMax = EW'(PMAX_L);
  localparam logic signed [EW-1:0] PosMin = EW'(PMIN_L);

  // request register
  logic                   req_valid_r;
  kind_t                  kind_r;
  logic [IN_W-1:0]        xv_r;
  logic [IN_W-1:0]        yv_r;
  logic                   adv;

  // move state
  logic [P-1:0]  x_pos_r,  x_pos_nxt;
  logic [P-1:0]  y_pos_r,  y_pos_nxt;
  logic [P-1:0]  x_span_r, x_span_nxt;
  logic [P-1:0]  y_span_r, y_span_nxt;
  logic          x_fwd_r,  x_fwd_nxt;
  logic          y_fwd_r,  y_fwd_nxt;
  logic [P-1:0]  n_r,      n_nxt;
  logic [P-1:0]  idx_r,    idx_nxt;
  logic [DW-1:0] x_err_r,  x_err_nxt;
  logic [DW-1:0] y_err_r,  y_err_nxt;
  logic          moving_r, moving_nxt;

  logic signed [EW-1:0] xv_e, yv_e, xp_e, yp_e, xl_e, yl_e;
  logic signed [EW-1:0] x_sum, y_sum, dx, dy, dxm, dym, xn_e, yn_e;
  logic                 abs_bad, rel_bad;
  logic [P-1:0]         sx_span, sy_span, s_n;
  logic [DW-1:0]        x_acc, y_acc, two_n;
  logic                 x_hit, y_hit;
  logic [P-1:0]         idx_inc;
  logic                 step_x, step_y;
  status_t              status;

  assign adv         = req_valid_r && res_ready;
  assign in_ch.ready = !req_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r <= in_ch.kind;
      xv_r   <= in_ch.x_value;
      yv_r   <= in_ch.y_value;
    end
  end

  // extended views for range checks
  assign xv_e = {{(EW-IN_W){xv_r[IN_W-1]}}, xv_r};
  assign yv_e = {{(EW-IN_W){yv_r[IN_W-1]}}, yv_r};
  assign xp_e = {{(EW-P){x_pos_r[P-1]}}, x_pos_r};
  assign yp_e = {{(EW-P){y_pos_r[P-1]}}, y_pos_r};
  assign xl_e = {{(EW-LEN_W){1'b0}}, x_len};
  assign yl_e = {{(EW-LEN_W){1'b0}}, y_len};

  assign abs_bad = xv_e[EW-1] || yv_e[EW-1] || (xv_e > xl_e) || (yv_e > yl_e) ||
                   (xv_e > PosMax) || (yv_e > PosMax);
  assign x_sum   = xp_e + xv_e;
  assign y_sum   = yp_e + yv_e;
  assign rel_bad = (x_sum < PosMin) || (x_sum > PosMax) ||
                   (y_sum < PosMin) || (y_sum > PosMax);

  // delta of a new move: target minus position, or the relative value itself
  assign dx  = (kind_r == K_ABS) ? (xv_e - xp_e) : xv_e;
  assign dy  = (kind_r == K_ABS) ? (yv_e - yp_e) : yv_e;
  assign dxm = dx[EW-1] ? -dx : dx;
  assign dym = dy[EW-1] ? -dy : dy;
  assign sx_span = dxm[P-1:0];
  assign sy_span = dym[P-1:0];
  assign s_n     = (sx_span > sy_span) ? sx_span : sy_span;

  // one DDA slot
  assign two_n   = {1'b0, n_r, 1'b0};
  assign x_acc   = x_err_r + {1'b0, x_span_r, 1'b0};
  assign y_acc   = y_err_r + {1'b0, y_span_r, 1'b0};
  assign x_hit   = x_acc >= two_n;
  assign y_hit   = y_acc >= two_n;
  assign idx_inc = idx_r + P'(1);

  always_comb begin
    x_pos_nxt  = x_pos_r;
    y_pos_nxt  = y_pos_r;
    x_span_nxt = x_span_r;
    y_span_nxt = y_span_r;
    x_fwd_nxt  = x_fwd_r;
    y_fwd_nxt  = y_fwd_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    x_err_nxt  = x_err_r;
    y_err_nxt  = y_err_r;
    moving_nxt = moving_r;
    step_x     = 1'b0;
    step_y     = 1'b0;
    status     = ST_NONE;
    case (kind_r)
      K_TICK: begin
        if (moving_r) begin
          step_x    = x_hit;
          step_y    = y_hit;
          x_err_nxt = x_hit ? (x_acc - two_n) : x_acc;
          y_err_nxt = y_hit ? (y_acc - two_n) : y_acc;
          if (x_hit) x_pos_nxt = x_fwd_r ? (x_pos_r + P'(1)) : (x_pos_r - P'(1));
          if (y_hit) y_pos_nxt = y_fwd_r ? (y_pos_r + P'(1)) : (y_pos_r - P'(1));
          idx_nxt    = idx_inc;
          moving_nxt = (idx_inc != n_r);
        end
      end
      K_ABS, K_REL: begin
        if (moving_r) begin
          status = ST_BUSY;
        end else if ((kind_r == K_ABS) ? abs_bad : rel_bad) begin
          status = ST_RANGE;
        end else begin
          status     = ST_ACCEPTED;
          x_span_nxt = sx_span;
          y_span_nxt = sy_span;
          x_fwd_nxt  = !dx[EW-1];
          y_fwd_nxt  = !dy[EW-1];
          n_nxt      = s_n;
          idx_nxt    = '0;
          x_err_nxt  = {2'b00, s_n};
          y_err_nxt  = {2'b00, s_n};
          moving_nxt = (s_n != '0);
        end
      end
      K_HOME: begin
        if (moving_r) begin
          status = ST_BUSY;
        end else begin
          status    = ST_ACCEPTED;
          x_pos_nxt = '0;
          y_pos_nxt = '0;
        end
      end
      default: status = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r  <= '0;
      y_pos_r  <= '0;
      x_span_r <= '0;
      y_span_r <= '0;
      x_fwd_r  <= 1'b0;
      y_fwd_r  <= 1'b0;
      n_r      <= '0;
      idx_r    <= '0;
      x_err_r  <= '0;
      y_err_r  <= '0;
      moving_r <= 1'b0;
    end else if (adv) begin
      x_pos_r  <= x_pos_nxt;
      y_pos_r  <= y_pos_nxt;
      x_span_r <= x_span_nxt;
      y_span_r <= y_span_nxt;
      x_fwd_r  <= x_fwd_nxt;
      y_fwd_r  <= y_fwd_nxt;
      n_r      <= n_nxt;
      idx_r    <= idx_nxt;
      x_err_r  <= x_err_nxt;
      y_err_r  <= y_err_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign xn_e = {{(EW-P){x_pos_nxt[P-1]}}, x_pos_nxt};
  assign yn_e = {{(EW-P){y_pos_nxt[P-1]}}, y_pos_nxt};

  assign res_valid    = req_valid_r;
  assign res.step_x   = step_x;
  assign res.dir_x    = x_fwd_nxt;
  assign res.step_y   = step_y;
  assign res.dir_y    = y_fwd_nxt;
  assign res.busy_res = moving_nxt;
  assign res.status   = status;
  assign res.x_now    = xn_e[IN_W-1:0];
  assign res.y_now    = yn_e[IN_W-1:0];

endmodule

// File: rtl/tsm_out_queue.sv
// Two-entry result queue: a two-slot circular buffer with read and write pointers.
module tsm_out_queue
  import tsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  res_t     push_data,
  output logic     push_ready,
  tsm_out_if.source out_ch
);

  res_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  res_t       head;

  assign pop        = out_ch.valid && out_ch.ready;
  assign push_ready = (cnt_r != 2'd2) || out_ch.ready;
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head            = ent_r[rd_ptr_r];
  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.step_x   = head.step_x;
  assign out_ch.dir_x    = head.dir_x;
  assign out_ch.step_y   = head.step_y;
  assign out_ch.dir_y    = head.dir_y;
  assign out_ch.busy_res = head.busy_res;
  assign out_ch.status   = head.status;
  assign out_ch.x_now    = head.x_now;
  assign out_ch.y_now    = head.y_now;

endmodule

// File: rtl/two_axis_coordinated_step_mover.sv
// Top level of the two-axis coordinated step mover.
// Two-axis stepper move generator. Each request (tick, absolute move, relative
// move or set home) gives one result. A move of N = max(|dx|,|dy|) slots runs
// as an integer DDA, one slot per tick, so each axis steps at most once per
// tick and lands exactly on its target after the last slot. A request is held
// in the request register, where the DDA update and the move setup
// are done, and its result goes into a two-entry output queue; one request is
// taken every cycle while the queue has room or the result side is taking.
// Commands sent during a move are rejected busy; absolute targets outside
// 0..axis length and relative moves past the position range are rejected.
// The axis length limits are set over the APB port at byte addresses 0 and 4.
module two_axis_coordinated_step_mover
  import tsm_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  tsm_in_if.sink            in_ch,
  tsm_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] x_len;
  logic [LEN_W-1:0] y_len;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  tsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .x_len   (x_len),
    .y_len   (y_len)
  );

  tsm_core #(.POS_BITS(POS_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .x_len     (x_len),
    .y_len     (y_len),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  tsm_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/tsm_checker.sv
// Port-level checker for the step mover, bound to the top level.
module tsm_checker
  import tsm_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input logic    step_x,
  input logic    step_y,
  input logic    busy_res,
  input status_t status
);

  // hold a pending result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // steps come only with ticks
  a_step_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (step_x || step_y) |-> status == ST_NONE)
    else $error("step on a command result");

  a_busy_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_BUSY |-> busy_res)
    else $error("busy reject while no move in progress");

  a_range_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_RANGE |-> !busy_res)
    else $error("range reject left a move running");

endmodule

bind two_axis_coordinated_step_mover tsm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .step_x    (out_ch.step_x),
  .step_y    (out_ch.step_y),
  .busy_res  (out_ch.busy_res),
  .status    (out_ch.status)
);
